/* hw/rtl/wmdu_pkg.sv */
package wmdu_pkg;

    // Operand and quotient width; the dividend and the result are twice as wide.
    localparam int WORD_W = 16;
    localparam int DATA_W = 2 * WORD_W;

    // Restoring divide steps per pipeline stage, and the stage count that follows.
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = WORD_W / STEPS_PER_STAGE;

    // Magnitude of the most negative signed quotient; a positive one stays below it.
    localparam logic [WORD_W-1:0] QPOS_MAX = WORD_W'(1) << (WORD_W - 1);

    typedef enum logic [1:0] {
        ACT_MULU = 2'd0,
        ACT_MULS = 2'd1,
        ACT_DIVU = 2'd2,
        ACT_DIVS = 2'd3
    } t_action;

    // Word in flight between the prepare stage and the output stage.
    // For a multiply, acc already holds the product.
    // For a divide, acc holds {partial remainder, dividend bits / quotient bits}.
    typedef struct packed {
        logic              is_div;
        logic              is_signed;
        logic              dneg;
        logic              qneg;
        logic              ovf_hi;
        logic              zero_div;
        logic [WORD_W-1:0] divisor;
        logic [DATA_W-1:0] acc;
    } t_stage;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              write_back;
        logic              flag_n;
        logic              flag_z;
        logic              flag_v;
        logic              flag_c;
        logic              zero_divide_trap;
    } t_result;

endpackage

/* hw/rtl/wmdu_if.sv */
interface wmdu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] dest_value;
    logic [15:0] source_word;

    modport source (output valid, output action, output dest_value, output source_word,
                    input ready);
    modport sink   (input valid, input action, input dest_value, input source_word,
                    output ready);
endinterface

interface wmdu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        write_back;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
    logic        flag_c;
    logic        zero_divide_trap;

    modport source (output valid, output result_value, output write_back, output flag_n,
                    output flag_z, output flag_v, output flag_c, output zero_divide_trap,
                    input ready);
    modport sink   (input valid, input result_value, input write_back, input flag_n,
                    input flag_z, input flag_v, input flag_c, input zero_divide_trap,
                    output ready);
endinterface

/* hw/rtl/wmdu_div_stage.sv */
module wmdu_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  wmdu_pkg::t_stage i_stage,
    output logic             o_valid,
    input  logic             i_ready,
    output wmdu_pkg::t_stage o_stage
);
    import wmdu_pkg::*;

    t_stage            r_stage;
    t_stage            n_stage;
    logic              r_valid;
    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;

    // STEPS_PER_STAGE restoring steps. The partial remainder stays below the divisor,
    // so the shifted trial value fits in one bit more than a word.
    always_comb begin
        n_stage = i_stage;
        trial   = '0;
        diff    = '0;
        if (i_stage.is_div) begin
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                trial = n_stage.acc[DATA_W-1:WORD_W-1];
                diff  = {1'b0, trial} - {2'b00, n_stage.divisor};
                if (!diff[WORD_W+1]) begin
                    n_stage.acc = {diff[WORD_W-1:0], n_stage.acc[WORD_W-2:0], 1'b1};
                end else begin
                    n_stage.acc = {trial[WORD_W-1:0], n_stage.acc[WORD_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_stage = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_stage <= n_stage;
        end
    end

endmodule

/* hw/rtl/word_multiply_divide_unit.sv */
// Word multiply and divide unit. Each input word selects an unsigned or signed
// 16x16 multiply, or an unsigned or signed 32/16 divide, and answers with one
// result word: the new register value, a write-back enable, the N Z V C flags
// and a divide-by-zero trap indication. The unit is a six-stage pipeline that
// takes one word per clock while the output is not held, and returns the
// results in order. The depth is set by the divider: the sixteen restoring
// quotient steps are spread four to a stage over four stages, between an
// operand-prepare stage and an output-formatting stage. Every stage carries
// its own valid bit and only waits when the stage after it is full and held,
// so bubbles close up and a stalled output loses or repeats nothing.
module word_multiply_divide_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wmdu_in_if.sink          i_cmd,
    wmdu_out_if.source       o_rsp
);
    import wmdu_pkg::*;

    // Chain of stage valid/ready/payload between prepare and output stages.
    logic   w_valid [DIV_STAGES+1];
    logic   w_ready [DIV_STAGES+1];
    t_stage w_stage [DIV_STAGES+1];

    // ------------------------------------------------------------------
    // Stage 1: operand preparation.
    // A multiply is done here in full as a 17x17 signed product; the
    // unsigned case simply zero-extends, and the low 32 bits are exact.
    // A divide takes magnitudes of both operands, and catches a quotient
    // that cannot fit in a word at all by comparing the dividend's high
    // half against the divisor.
    // ------------------------------------------------------------------
    t_action            in_action;
    logic [WORD_W-1:0]  in_lo;
    logic [WORD_W-1:0]  in_src;
    logic               in_signed;
    logic signed [WORD_W:0]     mul_a;
    logic signed [WORD_W:0]     mul_b;
    logic signed [2*WORD_W+1:0] mul_p;
    logic [DATA_W-1:0]  dmag;
    logic [WORD_W-1:0]  smag;
    logic               dneg;
    logic               sneg;
    t_stage             n_prep;
    t_stage             r_prep;
    logic               r_prep_valid;

    assign in_action = t_action'(i_cmd.action);
    assign in_lo     = i_cmd.dest_value[WORD_W-1:0];
    assign in_src    = i_cmd.source_word;
    assign in_signed = (in_action == ACT_MULS) || (in_action == ACT_DIVS);

    always_comb begin
        mul_a = $signed({in_signed & in_lo[WORD_W-1], in_lo});
        mul_b = $signed({in_signed & in_src[WORD_W-1], in_src});
        mul_p = mul_a * mul_b;

        dneg = in_signed && i_cmd.dest_value[DATA_W-1];
        sneg = in_signed && in_src[WORD_W-1];
        dmag = dneg ? (DATA_W'(0) - i_cmd.dest_value) : i_cmd.dest_value;
        smag = sneg ? (WORD_W'(0) - in_src) : in_src;

        n_prep.is_div    = (in_action == ACT_DIVU) || (in_action == ACT_DIVS);
        n_prep.is_signed = in_signed;
        n_prep.dneg      = dneg;
        n_prep.qneg      = dneg ^ sneg;
        n_prep.ovf_hi    = (dmag[DATA_W-1:WORD_W] >= smag);
        n_prep.zero_div  = (in_src == '0);
        n_prep.divisor   = smag;
        n_prep.acc       = n_prep.is_div ? dmag : mul_p[DATA_W-1:0];
    end

    assign i_cmd.ready = !r_prep_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_prep_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_prep <= n_prep;
        end
    end

    assign w_valid[0] = r_prep_valid;
    assign w_stage[0] = r_prep;

    // ------------------------------------------------------------------
    // Stages 2 to 5: quotient steps. Multiply words pass straight through.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        wmdu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 6: result formatting and output register.
    // Priority for a divide: zero divisor, then quotient overflow, then a
    // normal result with signs put back on quotient and remainder. The
    // remainder takes the sign of the dividend.
    // ------------------------------------------------------------------
    t_stage            fin;
    logic [WORD_W-1:0] qmag;
    logic [WORD_W-1:0] rmag;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
    logic              ovf;
    t_result           n_out;
    t_result           r_out;
    logic              r_out_valid;

    assign fin  = w_stage[DIV_STAGES];
    assign qmag = fin.acc[WORD_W-1:0];
    assign rmag = fin.acc[DATA_W-1:WORD_W];

    always_comb begin
        quo = fin.qneg ? (WORD_W'(0) - qmag) : qmag;
        rem = fin.dneg ? (WORD_W'(0) - rmag) : rmag;
        // A negative quotient may reach one step further than a positive one.
        ovf = fin.ovf_hi || (fin.is_signed &&
              (fin.qneg ? (qmag > QPOS_MAX) : (qmag >= QPOS_MAX)));

        n_out = '0;
        if (!fin.is_div) begin
            n_out.result_value = fin.acc;
            n_out.write_back   = 1'b1;
            n_out.flag_n       = fin.acc[DATA_W-1];
            n_out.flag_z       = (fin.acc == '0);
        end else if (fin.zero_div) begin
            n_out.zero_divide_trap = 1'b1;
        end else if (ovf) begin
            n_out.flag_n = 1'b1;
            n_out.flag_v = 1'b1;
        end else begin
            n_out.result_value = {rem, quo};
            n_out.write_back   = 1'b1;
            n_out.flag_n       = quo[WORD_W-1];
            n_out.flag_z       = (quo == '0);
        end
    end

    assign w_ready[DIV_STAGES] = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[DIV_STAGES]) begin
            r_out_valid <= w_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[DIV_STAGES] && w_valid[DIV_STAGES]) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.result_value     = r_out.result_value;
    assign o_rsp.write_back       = r_out.write_back;
    assign o_rsp.flag_n           = r_out.flag_n;
    assign o_rsp.flag_z           = r_out.flag_z;
    assign o_rsp.flag_v           = r_out.flag_v;
    assign o_rsp.flag_c           = r_out.flag_c;
    assign o_rsp.zero_divide_trap = r_out.zero_divide_trap;

endmodule

/* verif/tb_word_multiply_divide_unit.sv */
module tb_word_multiply_divide_unit;
    import wmdu_pkg::*;

    // One command word as the driver offers it to the unit.
    typedef struct {
        t_action     act;
        logic [31:0] dest;
        logic [15:0] src;
    } t_cmd_word;

    logic i_clk;
    logic i_rst_n;

    wmdu_in_if  cmd_if ();
    wmdu_out_if rsp_if ();

    word_multiply_divide_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Command words waiting to be driven, and the results the unit still owes,
    // oldest first. Every accepted command produces exactly one result.
    t_cmd_word pending_words[$];
    t_result   owed_results[$];
    int        mismatch_count = 0;

    // Idle rates in percent for the command side and the result side. The
    // stimulus process changes them between phases, always at a falling edge.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The stimulus process bumps hold_asks to ask the result side for one long
    // hold-off; the result side counts the stretch down in its own process.
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    t_cmd_word next_word;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected result of one command. Multiplies take the low word of the
    // destination; divides take the full 32-bit dividend. Quotient and
    // remainder are worked out in 64-bit signed arithmetic, where truncation
    // toward zero gives the remainder the sign of the dividend.
    function automatic t_result predict_result(input t_action act, input logic [31:0] dest,
                                               input logic [15:0] src);
        t_result res;
        longint  lhs;
        longint  rhs;
        longint  quo;
        longint  rem;
        logic    too_big;
        res = '0;
        if (act == ACT_MULU || act == ACT_MULS) begin
            if (act == ACT_MULU) begin
                lhs = dest[15:0];
                rhs = src;
            end else begin
                lhs = $signed(dest[15:0]);
                rhs = $signed(src);
            end
            res.result_value = 32'(lhs * rhs);
            res.write_back   = 1'b1;
            res.flag_n       = res.result_value[31];
            res.flag_z       = (res.result_value == 32'd0);
            return res;
        end
        // A zero divisor takes the trap and leaves every flag clear.
        if (src == 16'd0) begin
            res.zero_divide_trap = 1'b1;
            return res;
        end
        if (act == ACT_DIVU) begin
            lhs = dest;
            rhs = src;
        end else begin
            lhs = $signed(dest);
            rhs = $signed(src);
        end
        quo = lhs / rhs;
        rem = lhs % rhs;
        if (act == ACT_DIVU)
            too_big = (quo > 65535);
        else
            too_big = (quo > 32767) || (quo < -32768);
        // A quotient that does not fit in a word sets V and N and writes nothing.
        if (too_big) begin
            res.flag_v = 1'b1;
            res.flag_n = 1'b1;
            return res;
        end
        res.result_value = {rem[15:0], quo[15:0]};
        res.write_back   = 1'b1;
        res.flag_n       = quo[15];
        res.flag_z       = (quo[15:0] == 16'd0);
        return res;
    endfunction

    // Operand word: mostly random, sometimes one of the corner values.
    function automatic logic [15:0] pick_operand();
        if ($urandom_range(3) != 0)
            return 16'($urandom);
        case ($urandom_range(6))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h0002;
            3:       return 16'h7fff;
            4:       return 16'h8000;
            5:       return 16'hfffe;
            default: return 16'hffff;
        endcase
    endfunction

    // Divide whose quotient fits, built backwards from a chosen quotient,
    // divisor and remainder so that the whole quotient range is reached.
    function automatic t_cmd_word fitting_divide(input logic is_signed);
        t_cmd_word wd;
        logic [15:0] div;
        longint quo;
        longint dvs;
        longint mag;
        longint rem;
        longint prod;
        div = pick_operand();
        if (div == 16'd0)
            div = 16'($urandom_range(65535, 1));
        if (!is_signed) begin
            wd.act  = ACT_DIVU;
            wd.src  = div;
            quo     = pick_operand();
            rem     = $urandom_range(int'(div) - 1);
            wd.dest = 32'(quo * div + rem);
        end else begin
            wd.act  = ACT_DIVS;
            wd.src  = div;
            dvs     = $signed(div);
            quo     = $signed(pick_operand());
            prod    = quo * dvs;
            mag     = (dvs < 0) ? -dvs : dvs;
            rem     = $urandom_range(int'(mag) - 1);
            // The remainder follows the sign of the dividend.
            if (prod < 0 || (prod == 0 && $urandom_range(1) == 1))
                rem = -rem;
            wd.dest = 32'(prod + rem);
        end
        return wd;
    endfunction

    // Random command: mostly multiplies and divides that succeed, the rest
    // raw random words (whose divides mostly overflow) and zero divisors.
    function automatic t_cmd_word random_word();
        t_cmd_word wd;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            wd.act  = ($urandom_range(1) == 1) ? ACT_MULS : ACT_MULU;
            wd.dest = {16'($urandom), pick_operand()};
            wd.src  = pick_operand();
        end else if (pick < 80) begin
            wd = fitting_divide($urandom_range(1) == 1);
        end else if (pick < 93) begin
            wd.act  = t_action'($urandom_range(3));
            wd.dest = $urandom;
            wd.src  = 16'($urandom);
        end else begin
            wd.act  = ($urandom_range(1) == 1) ? ACT_DIVS : ACT_DIVU;
            wd.dest = $urandom;
            wd.src  = 16'd0;
        end
        return wd;
    endfunction

    task automatic push_word(input t_action act, input logic [31:0] dest,
                             input logic [15:0] src);
        t_cmd_word wd;
        wd.act  = act;
        wd.dest = dest;
        wd.src  = src;
        pending_words.push_back(wd);
    endtask

    task automatic push_random(input int count);
        repeat (count) pending_words.push_back(random_word());
    endtask

    // Returns once every queued word has been accepted and every result has
    // come back. Sampling at the falling edge keeps clear of the clocked blocks.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_words.size() != 0 || cmd_if.valid || owed_results.size() != 0);
    endtask

    // Command driver. A word on offer stays put until it is taken; a new one
    // goes out only when the channel is free and the sender does not idle.
    initial begin
        cmd_if.valid       = 1'b0;
        cmd_if.action      = ACT_MULU;
        cmd_if.dest_value  = '0;
        cmd_if.source_word = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_word = pending_words.pop_front();
                cmd_if.valid       <= 1'b1;
                cmd_if.action      <= next_word.act;
                cmd_if.dest_value  <= next_word.dest;
                cmd_if.source_word <= next_word.src;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result side ready. A requested hold-off keeps ready low for a long
    // stretch so that the pipeline fills and pushes back on the command side.
    initial rsp_if.ready = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_seen != hold_asks) begin
            hold_seen    <= hold_asks;
            hold_left    <= 300;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        return 1;
    endfunction

    // Monitor. An accepted command queues its predicted result; an accepted
    // result is checked field by field against the oldest one owed.
    always @(posedge i_clk) begin : monitor
        t_result want;
        int      bad;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                owed_results.push_back(predict_result(t_action'(cmd_if.action),
                                                      cmd_if.dest_value,
                                                      cmd_if.source_word));
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result with none expected, actual value %h", $time,
                             rsp_if.result_value);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = owed_results.pop_front();
                    bad  = 0;
                    bad += compare_field("result_value", want.result_value,
                                         rsp_if.result_value);
                    bad += compare_field("write_back", want.write_back, rsp_if.write_back);
                    bad += compare_field("flag_n", want.flag_n, rsp_if.flag_n);
                    bad += compare_field("flag_z", want.flag_z, rsp_if.flag_z);
                    bad += compare_field("flag_v", want.flag_v, rsp_if.flag_v);
                    bad += compare_field("flag_c", want.flag_c, rsp_if.flag_c);
                    bad += compare_field("zero_divide_trap", want.zero_divide_trap,
                                         rsp_if.zero_divide_trap);
                    if (bad != 0)
                        mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words: operand extremes, every operation, the zero
        // divisor, quotient overflow on both sides and the signed edges.
        push_word(ACT_MULU, 32'h0000_ffff, 16'hffff);
        push_word(ACT_MULU, 32'hdead_0000, 16'h1234);
        push_word(ACT_MULU, 32'hffff_0003, 16'h0002);
        push_word(ACT_MULS, 32'h0000_8000, 16'h8000);
        push_word(ACT_MULS, 32'h0000_8000, 16'h7fff);
        push_word(ACT_MULS, 32'h0000_7fff, 16'h7fff);
        push_word(ACT_MULS, 32'h1234_ffff, 16'h0001);
        push_word(ACT_MULS, 32'h0000_0000, 16'hffff);
        push_word(ACT_DIVU, 32'h1234_5678, 16'h0000);
        push_word(ACT_DIVS, 32'h8000_0000, 16'h0000);
        push_word(ACT_DIVU, 32'hffff_ffff, 16'h0001);
        push_word(ACT_DIVU, 32'hffff_ffff, 16'hffff);
        push_word(ACT_DIVU, 32'hfffe_ffff, 16'hffff);
        push_word(ACT_DIVU, 32'h0000_ffff, 16'h0001);
        push_word(ACT_DIVU, 32'h0000_0000, 16'h0005);
        push_word(ACT_DIVU, 32'h0001_0000, 16'h0001);
        push_word(ACT_DIVS, 32'h8000_0000, 16'hffff);
        push_word(ACT_DIVS, 32'hffff_8000, 16'h0001);
        push_word(ACT_DIVS, 32'h0000_8000, 16'h0001);
        push_word(ACT_DIVS, 32'hffff_8000, 16'hffff);
        push_word(ACT_DIVS, 32'hffff_fff9, 16'h0002);
        push_word(ACT_DIVS, 32'h0000_0007, 16'hfffe);
        push_word(ACT_DIVS, 32'hffff_fff9, 16'hfffe);
        push_word(ACT_DIVS, 32'h7fff_ffff, 16'h8000);
        push_word(ACT_DIVS, 32'h0000_0000, 16'h8000);
        wait_drained();

        // The sender mostly streams while the receiver often stalls.
        send_idle_pct = 11;
        recv_idle_pct = 63;
        push_random(550);
        wait_drained();

        // Roles swapped: the sender is sparse and the receiver nearly always ready.
        send_idle_pct = 63;
        recv_idle_pct = 11;
        push_random(550);
        // The sender stops here until the unit has returned everything it owes.
        wait_drained();

        // No idling on either side, with one long receiver hold-off at the
        // start so the pipeline fills and stalls the command channel.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(550);
        hold_asks = hold_asks + 1;
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop if the unit hangs; a correct run takes a small fraction of this.
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
